// ===== rtl/core/dht_pkg.sv =====
// Package for the double-hash string table: transaction structs, result
// codes, hash seeds and the controller/datapath command and status structs.
// No dependencies.
package dht_pkg;

  typedef struct packed {
    logic               action;
    logic [7:0]         name_byte;
    logic               name_last;
    logic signed [31:0] height_value;
    logic signed [31:0] weight_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [11:0]        slot_index;
    logic signed [31:0] found_height;
    logic signed [31:0] found_weight;
  } out_item_t;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_FOUND     = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_TOO_LONG  = 3'd4;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  localparam logic [31:0] STEP_SEED = 32'd17;
  localparam logic [31:0] BASE_SEED = 32'd5381;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_PROBE = 3'b100
  } state_t;

  typedef struct packed {
    logic take;       // accept one name byte
    logic start;      // last byte taken, begin probing
    logic reject;     // last byte taken, name too long
    logic issue;      // probe state: keep issuing slot reads
    logic clr_write;  // clear sweep: zero one slot
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic over;       // next byte would overflow the name buffer
    logic finish;     // probe resolved this cycle
    logic out_busy;   // result register still holds a transaction
  } sts_t;

endpackage

// ===== rtl/core/dht_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dht_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/dht_ctrl.sv =====
// Controller for the double-hash string table: clear sweep, byte intake,
// probe sequencing. Depends on dht_pkg.
module dht_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_last,
  output logic          in_stall,
  input  dht_pkg::sts_t sts,
  output dht_pkg::cmd_t cmd
);

  dht_pkg::state_t state_r, state_nxt;

  always_comb begin
    in_stall      = (state_r != dht_pkg::S_IDLE) || (sts.out_busy && in_last);
    cmd.take      = in_valid && !in_stall;
    cmd.start     = cmd.take && in_last && !sts.over;
    cmd.reject    = cmd.take && in_last && sts.over;
    cmd.issue     = (state_r == dht_pkg::S_PROBE);
    cmd.clr_write = (state_r == dht_pkg::S_CLEAR);
    state_nxt     = state_r;
    unique case (state_r)
      dht_pkg::S_CLEAR: if (sts.clr_last) state_nxt = dht_pkg::S_IDLE;
      dht_pkg::S_IDLE:  if (cmd.start) state_nxt = dht_pkg::S_PROBE;
      dht_pkg::S_PROBE: if (sts.finish) state_nxt = dht_pkg::S_IDLE;
      default:          state_nxt = dht_pkg::S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dht_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/dht_dpath.sv =====
// Datapath for the double-hash string table: key buffer, both hashes, probe
// pointer, slot memories and result register. Depends on dht_pkg, dht_ram.
module dht_dpath #(
  parameter int TABLE_SLOTS    = 4096,
  parameter int MAX_NAME_BYTES = 48
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dht_pkg::in_item_t   in_item,
  input  dht_pkg::cmd_t       cmd,
  output dht_pkg::sts_t       sts,
  input  logic                out_stall,
  output logic                out_valid,
  output dht_pkg::out_item_t  out_item
);

  localparam int SW = $clog2(TABLE_SLOTS);
  localparam int LW = $clog2(MAX_NAME_BYTES + 2);
  localparam int NW = (MAX_NAME_BYTES + 7) / 8;
  localparam int MW = 1 + LW + 64;

  logic [7:0]          key_byte_r [MAX_NAME_BYTES];
  logic [LW-1:0]       key_len_r;
  logic [31:0]         step_r, base_r;
  logic [31:0]         chr, step_nxt, base_nxt;
  logic [NW-1:0][63:0] key_words;

  logic                action_r;
  logic [31:0]         height_r, weight_r;
  logic [SW-1:0]       pos_r, eval_slot_r, clr_cnt_r;
  logic [SW:0]         iss_cnt_r;
  logic                eval_v_r, eval_last_r;
  logic                issue_now, hit, name_eq;
  logic [31:0]         slot_wide;

  logic                meta_we;
  logic [SW-1:0]       meta_waddr;
  logic [MW-1:0]       meta_wdata, meta_rdata;
  logic [NW-1:0][63:0] name_rdata;
  logic                name_we;

  logic                out_valid_r;
  dht_pkg::out_item_t  out_r;

  // Pack stored bytes into 64-bit words, little-endian within a word.
  always_comb begin
    for (int w = 0; w < NW; w++) begin
      for (int b = 0; b < 8; b++) begin
        if (w * 8 + b < MAX_NAME_BYTES) begin
          key_words[w][8*b +: 8] = key_byte_r[w * 8 + b];
        end else begin
          key_words[w][8*b +: 8] = 8'h00;
        end
      end
    end
  end

  assign chr      = {{24{in_item.name_byte[7]}}, in_item.name_byte};
  assign step_nxt = chr + (step_r << 6) + (step_r << 16) - step_r;
  assign base_nxt = (base_r << 5) + base_r + chr;

  // Probe evaluation on the registered memory read.
  always_comb begin
    name_eq = 1'b1;
    for (int w = 0; w < NW; w++) begin
      if (name_rdata[w] != key_words[w]) name_eq = 1'b0;
    end
  end

  assign hit = (action_r == dht_pkg::ACT_INSERT) ? !meta_rdata[MW-1] :
               (meta_rdata[MW-1] && (meta_rdata[MW-2 -: LW] == key_len_r) && name_eq);

  assign sts.finish   = eval_v_r && (hit || eval_last_r);
  assign sts.over     = (key_len_r >= LW'(MAX_NAME_BYTES));
  assign sts.clr_last = (clr_cnt_r == {SW{1'b1}});
  assign sts.out_busy = out_valid_r;

  assign issue_now = cmd.issue && (iss_cnt_r < (SW+1)'(TABLE_SLOTS)) && !sts.finish;

  assign name_we    = sts.finish && hit && (action_r == dht_pkg::ACT_INSERT);
  assign meta_we    = cmd.clr_write || name_we;
  assign meta_waddr = cmd.clr_write ? clr_cnt_r : eval_slot_r;
  assign meta_wdata = cmd.clr_write ? '0 : {1'b1, key_len_r, weight_r, height_r};

  dht_ram #(.WIDTH(MW), .DEPTH(TABLE_SLOTS)) u_meta (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (pos_r),
    .rdata (meta_rdata)
  );

  for (genvar g = 0; g < NW; g++) begin : g_name
    dht_ram #(.WIDTH(64), .DEPTH(TABLE_SLOTS)) u_name (
      .clk   (clk),
      .we    (name_we),
      .waddr (eval_slot_r),
      .wdata (key_words[g]),
      .raddr (pos_r),
      .rdata (name_rdata[g])
    );
  end

  assign slot_wide = 32'(eval_slot_r);

  // Key intake and hashes; restore seeds once a transaction resolves.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.reject || sts.finish) begin
      for (int i = 0; i < MAX_NAME_BYTES; i++) key_byte_r[i] <= 8'h00;
      key_len_r <= '0;
      step_r    <= dht_pkg::STEP_SEED;
      base_r    <= dht_pkg::BASE_SEED;
    end else if (cmd.take) begin
      if (!sts.over) begin
        for (int i = 0; i < MAX_NAME_BYTES; i++) begin
          if (key_len_r == LW'(i)) key_byte_r[i] <= in_item.name_byte;
        end
        key_len_r <= key_len_r + LW'(1);
        step_r    <= step_nxt;
        base_r    <= base_nxt;
      end else begin
        key_len_r <= LW'(MAX_NAME_BYTES + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      action_r <= in_item.action;
      height_r <= in_item.height_value;
      weight_r <= in_item.weight_value;
    end
  end

  // Probe pointer walks base + k*step one slot per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eval_v_r  <= 1'b0;
      iss_cnt_r <= '0;
      clr_cnt_r <= '0;
    end else begin
      eval_v_r <= issue_now;
      if (cmd.clr_write) clr_cnt_r <= clr_cnt_r + SW'(1);
      if (cmd.start) begin
        iss_cnt_r <= '0;
      end else if (issue_now) begin
        iss_cnt_r <= iss_cnt_r + (SW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      pos_r <= base_nxt[SW-1:0];
    end else if (issue_now) begin
      pos_r <= pos_r + step_r[SW-1:0];
    end
    eval_slot_r <= pos_r;
    eval_last_r <= (iss_cnt_r == (SW+1)'(TABLE_SLOTS - 1));
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.reject || sts.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.reject) begin
      out_r <= '{status: dht_pkg::ST_TOO_LONG, slot_index: '0,
                 found_height: '0, found_weight: '0};
    end else if (sts.finish) begin
      out_r.slot_index   <= hit ? slot_wide[11:0] : 12'd0;
      out_r.found_height <= '0;
      out_r.found_weight <= '0;
      if (action_r == dht_pkg::ACT_INSERT) begin
        out_r.status <= hit ? dht_pkg::ST_INSERTED : dht_pkg::ST_FULL;
      end else begin
        out_r.status <= hit ? dht_pkg::ST_FOUND : dht_pkg::ST_NOT_FOUND;
        if (hit) begin
          out_r.found_height <= meta_rdata[31:0];
          out_r.found_weight <= meta_rdata[63:32];
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== rtl/core/double_hash_string_table.sv =====
// Double-hash string table, top level. Depends on dht_pkg, dht_ctrl, dht_dpath.
// On a final byte the probe pointer loads at the accepting edge and the slot
// memories are read one probe per cycle, each probe resolved the cycle after its
// read, until a probe hits or the last slot has been probed. After reset a sweep
// clears the occupancy bits; no transaction is taken while it runs.
module double_hash_string_table #(
  parameter int TABLE_SLOTS    = 4096,
  parameter int MAX_NAME_BYTES = 48
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dht_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output dht_pkg::out_item_t out_item
);

  dht_pkg::cmd_t cmd;
  dht_pkg::sts_t sts;

  dht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_item.name_last),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  dht_dpath #(
    .TABLE_SLOTS    (TABLE_SLOTS),
    .MAX_NAME_BYTES (MAX_NAME_BYTES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ===== rtl/core/dht_chk.sv =====
// Port-level checker for the double-hash string table, bound to the top level.
// Depends on dht_pkg.
module dht_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input dht_pkg::out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result transaction changed while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.status <= dht_pkg::ST_TOO_LONG)
    else $error("status code out of range");

  a_miss_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == dht_pkg::ST_NOT_FOUND ||
                  out_item.status == dht_pkg::ST_FULL ||
                  out_item.status == dht_pkg::ST_TOO_LONG) |-> out_item.slot_index == 12'd0)
    else $error("slot index set on a miss");

  a_record_only_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != dht_pkg::ST_FOUND |->
      out_item.found_height == 32'sd0 && out_item.found_weight == 32'sd0)
    else $error("record returned without a match");

endmodule

bind double_hash_string_table dht_chk u_dht_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

// ===== tb/tb_double_hash_string_table.sv =====
// Testbench for double_hash_string_table: directed table, then random insert and
// search transactions, checked against an in-bench model of the slot table; three
// directed searches use a fixed expected status. Depends on dht_pkg and the double_hash_string_table RTL.
module tb_double_hash_string_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS     = 4096;
  localparam int NAME_MAX  = 48;
  localparam int N_RANDOM  = 1350;
  localparam int MISS_CAP  = 50;
  localparam int HOLD_AT   = 800;
  localparam int HOLD_LEN  = 400;

  typedef struct {
    dht_pkg::in_item_t  item;
    bit                 typed;
    dht_pkg::out_item_t exp;
  } stim_t;

  typedef struct {
    int       len;
    bit [7:0] b[64];
  } name_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  dht_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  dht_pkg::out_item_t out_item;

  double_hash_string_table DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  always #4 clk = ~clk;

  // table model state
  bit        tbl_used[SLOTS];
  bit [7:0]  tbl_name[SLOTS][NAME_MAX];
  int        tbl_len[SLOTS];
  bit [31:0] tbl_height[SLOTS];
  bit [31:0] tbl_weight[SLOTS];
  bit [7:0]  key_bytes[NAME_MAX];
  int        key_len;
  bit [31:0] step_h;
  bit [31:0] base_h;

  stim_t              stim_q[$];
  dht_pkg::out_item_t pending_q[$];
  name_t              pool[$];
  int                 sent_idx = 0;
  int                 drv_idx = -1;
  int                 errors = 0;
  bit                 hold_off = 1'b0;
  bit                 quiet = 1'b0;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void clear_key();
    foreach (key_bytes[i]) key_bytes[i] = '0;
    key_len = 0;
    step_h = dht_pkg::STEP_SEED;
    base_h = dht_pkg::BASE_SEED;
  endfunction

  function automatic bit key_equal(int s);
    if (tbl_len[s] != key_len) return 1'b0;
    for (int i = 0; i < key_len; i++)
      if (tbl_name[s][i] != key_bytes[i]) return 1'b0;
    return 1'b1;
  endfunction

  // Advance the table model by one transaction; return 1 when a result is due.
  function automatic bit table_step(dht_pkg::in_item_t it, output dht_pkg::out_item_t res);
    bit [31:0] c;
    bit [31:0] s;
    c = {{24{it.name_byte[7]}}, it.name_byte};
    res = '0;
    if (key_len < NAME_MAX) begin
      key_bytes[key_len] = it.name_byte;
      key_len++;
      step_h = c + (step_h << 6) + (step_h << 16) - step_h;
      base_h = (base_h << 5) + base_h + c;
    end else begin
      key_len = NAME_MAX + 1;
    end
    if (!it.name_last) return 1'b0;
    if (key_len > NAME_MAX) begin
      res.status = dht_pkg::ST_TOO_LONG;
    end else if (it.action == dht_pkg::ACT_INSERT) begin
      res.status = dht_pkg::ST_FULL;
      for (int k = 0; k < SLOTS; k++) begin
        s = (base_h + k * step_h) & (SLOTS - 1);
        if (!tbl_used[s]) begin
          tbl_used[s] = 1'b1;
          for (int i = 0; i < NAME_MAX; i++) tbl_name[s][i] = key_bytes[i];
          tbl_len[s] = key_len;
          tbl_height[s] = it.height_value;
          tbl_weight[s] = it.weight_value;
          res.status = dht_pkg::ST_INSERTED;
          res.slot_index = s[11:0];
          break;
        end
      end
    end else begin
      res.status = dht_pkg::ST_NOT_FOUND;
      for (int k = 0; k < SLOTS; k++) begin
        s = (base_h + k * step_h) & (SLOTS - 1);
        if (tbl_used[s] && key_equal(s)) begin
          res.status = dht_pkg::ST_FOUND;
          res.slot_index = s[11:0];
          res.found_height = tbl_height[s];
          res.found_weight = tbl_weight[s];
          break;
        end
      end
    end
    clear_key();
    return 1'b1;
  endfunction

  function automatic void add_row(bit act, bit [7:0] b, bit last, bit [31:0] h,
                                  bit [31:0] w, bit typed, logic [2:0] st);
    stim_t r;
    r.item.action = act;
    r.item.name_byte = b;
    r.item.name_last = last;
    r.item.height_value = h;
    r.item.weight_value = w;
    r.typed = typed;
    r.exp = '0;
    r.exp.status = st;
    stim_q.push_back(r);
  endfunction

  // Queue one name; only the final transaction carries the real action and record.
  function automatic void add_name(name_t nm, bit act);
    for (int i = 0; i < nm.len; i++)
      add_row((i == nm.len - 1) ? act : 1'($urandom), nm.b[i], i == nm.len - 1,
              $urandom, $urandom, 1'b0, dht_pkg::ST_INSERTED);
  endfunction

  function automatic name_t random_name();
    name_t nm;
    nm.len = ($urandom_range(99) < 3) ? $urandom_range(NAME_MAX + 4, NAME_MAX - 3)
                                      : $urandom_range(6, 1);
    for (int i = 0; i < nm.len; i++) nm.b[i] = $urandom;
    return nm;
  endfunction

  function automatic void build_stimulus();
    int r;
    int misses;
    name_t nm;
    // directed table
    add_row(dht_pkg::ACT_SEARCH, 8'h41, 1, 0, 0, 1, dht_pkg::ST_NOT_FOUND);  // empty table
    add_row(dht_pkg::ACT_INSERT, 8'h00, 1, 32'h7fffffff, 32'h80000000, 0,
            dht_pkg::ST_INSERTED);
    add_row(dht_pkg::ACT_SEARCH, 8'h00, 1, 0, 0, 0, dht_pkg::ST_INSERTED);
    add_row(dht_pkg::ACT_INSERT, 8'hff, 1, 32'h80000000, 32'h7fffffff, 0,
            dht_pkg::ST_INSERTED);
    add_row(dht_pkg::ACT_SEARCH, 8'hff, 1, 32'hffffffff, 32'hffffffff, 0,
            dht_pkg::ST_INSERTED);
    add_row(dht_pkg::ACT_INSERT, 8'h80, 1, 32'hffffffff, 32'h0, 0, dht_pkg::ST_INSERTED);
    add_row(dht_pkg::ACT_SEARCH, 8'h80, 1, 0, 0, 0, dht_pkg::ST_INSERTED);
    add_row(dht_pkg::ACT_INSERT, 8'h7f, 1, 32'h0, 32'hffffffff, 0, dht_pkg::ST_INSERTED);
    add_row(dht_pkg::ACT_SEARCH, 8'h00, 0, 32'h5, 32'h6, 0, dht_pkg::ST_INSERTED);  // two zero bytes
    add_row(dht_pkg::ACT_INSERT, 8'h00, 1, 32'h11, 32'h22, 0, dht_pkg::ST_INSERTED);
    add_row(dht_pkg::ACT_INSERT, 8'h00, 0, 0, 0, 0, dht_pkg::ST_INSERTED);
    add_row(dht_pkg::ACT_SEARCH, 8'h00, 1, 0, 0, 0, dht_pkg::ST_INSERTED);
    add_row(dht_pkg::ACT_INSERT, 8'h00, 1, 32'h1, 32'h2, 0, dht_pkg::ST_INSERTED);  // duplicate
    add_row(dht_pkg::ACT_SEARCH, 8'h00, 1, 0, 0, 0, dht_pkg::ST_INSERTED);
    add_row(dht_pkg::ACT_SEARCH, 8'h01, 1, 0, 0, 1, dht_pkg::ST_NOT_FOUND);
    add_row(dht_pkg::ACT_SEARCH, 8'h00, 0, 0, 0, 0, dht_pkg::ST_INSERTED);
    add_row(dht_pkg::ACT_SEARCH, 8'h01, 1, 0, 0, 1, dht_pkg::ST_NOT_FOUND);
    // random part: mostly inserts and hits, a capped number of searches for new random names
    misses = 0;
    while (stim_q.size() < N_RANDOM) begin
      r = $urandom_range(99);
      if (pool.size() == 0 || r < 45) begin
        nm = random_name();
        add_name(nm, dht_pkg::ACT_INSERT);
        if (nm.len <= NAME_MAX) pool.push_back(nm);
      end else if (r < 55) begin
        add_name(pool[$urandom_range(pool.size() - 1)], dht_pkg::ACT_INSERT);
      end else if (r < 93 || misses >= MISS_CAP) begin
        add_name(pool[$urandom_range(pool.size() - 1)], dht_pkg::ACT_SEARCH);
      end else begin
        nm = random_name();
        if (nm.len <= NAME_MAX) misses++;
        add_name(nm, dht_pkg::ACT_SEARCH);
      end
    end
  endfunction

  // sender
  initial begin
    build_stimulus();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    forever begin
      @(negedge clk);
      quiet = (sent_idx >= 300 && sent_idx < 500);
      // hold the offered transaction until the checker has seen it accepted
      if (!in_valid || sent_idx != drv_idx) begin
        if (sent_idx < stim_q.size() && (quiet || $urandom_range(99) >= 19)) begin
          in_item <= stim_q[sent_idx].item;
          in_valid <= 1'b1;
          drv_idx = sent_idx;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(negedge clk)
    out_stall <= hold_off || (!quiet && $urandom_range(99) < 19);

  // one long hold-off so the block backs up into its input
  initial begin
    wait (sent_idx >= HOLD_AT);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_LEN) @(posedge clk);
    hold_off = 1'b0;
  end

  // accept, predict and check
  always @(posedge clk) begin
    dht_pkg::out_item_t res;
    dht_pkg::out_item_t want;
    if (rst_n && in_valid && !in_stall) begin
      if (table_step(in_item, res)) begin
        if (stim_q[sent_idx].typed) pending_q.push_back(stim_q[sent_idx].exp);
        else pending_q.push_back(res);
      end
      sent_idx++;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected transaction", out_item.status, 0);
      end else begin
        want = pending_q.pop_front();
        if (out_item.status !== want.status)
          report_mismatch("status", out_item.status, want.status);
        if (out_item.slot_index !== want.slot_index)
          report_mismatch("slot_index", out_item.slot_index, want.slot_index);
        if (out_item.found_height !== want.found_height)
          report_mismatch("found_height", out_item.found_height, want.found_height);
        if (out_item.found_weight !== want.found_weight)
          report_mismatch("found_weight", out_item.found_weight, want.found_weight);
      end
    end
  end

  initial begin
    foreach (tbl_used[i]) tbl_used[i] = 1'b0;
    clear_key();
    wait (rst_n && stim_q.size() > 0 && sent_idx == stim_q.size());
    wait (pending_q.size() == 0);
    repeat (SLOTS + 100) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/dht_pkg.sv
rtl/core/dht_ram.sv
rtl/core/dht_ctrl.sv
rtl/core/dht_dpath.sv
rtl/core/double_hash_string_table.sv
rtl/core/dht_chk.sv
tb/tb_double_hash_string_table.sv
